/* hdl/hmr_pkg.sv */
// ----------------------------------------------------------------------------
// hmr_pkg
// Types and constants shared by the histogram max rectangle core.
// ----------------------------------------------------------------------------
package hmr_pkg;

   localparam int HEIGHT_W = 16;
   localparam int BARW_W   = 16;
   localparam int STEPW_W  = 26;
   localparam int AREA_W   = 42;
   localparam int ENTRY_W  = STEPW_W + HEIGHT_W;

   localparam logic [STEPW_W-1:0] STEPW_MAX = {STEPW_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FLUSH_RD,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   // saturating width accumulate
   function automatic logic [STEPW_W-1:0] sat_add(input logic [STEPW_W-1:0] a,
                                                  input logic [STEPW_W-1:0] b);
      logic [STEPW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[STEPW_W] ? STEPW_MAX : s[STEPW_W-1:0];
   endfunction

endpackage

/* hdl/hmr_req_if.sv */
// ----------------------------------------------------------------------------
// hmr_req_if
// Bar request channel: valid/ready handshake with one histogram bar.
// ----------------------------------------------------------------------------
interface hmr_req_if;
   logic                          valid;
   logic                          ready;
   logic [hmr_pkg::BARW_W-1:0]    bar_width;
   logic [hmr_pkg::HEIGHT_W-1:0]  bar_height;
   logic                          last_bar;

   modport source (output valid, output bar_width, output bar_height,
                   output last_bar, input ready);
   modport sink   (input valid, input bar_width, input bar_height,
                   input last_bar, output ready);
endinterface

/* hdl/hmr_rsp_if.sv */
// ----------------------------------------------------------------------------
// hmr_rsp_if
// Result channel: valid/ready handshake with maximum area and overflow flag.
// ----------------------------------------------------------------------------
interface hmr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hmr_pkg::AREA_W-1:0]  max_area;
   logic                        overflow;

   modport source (output valid, output max_area, output overflow, input ready);
   modport sink   (input valid, input max_area, input overflow, output ready);
endinterface

/* hdl/histogram_max_rectangle_core.sv */
// ----------------------------------------------------------------------------
// histogram_max_rectangle_core
// Largest rectangle under a histogram of variable-width bars, using a
// monotonic step stack in a synchronous memory (one write, one read port).
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | accepted when
//  req     | in  | bar_width, bar_height, last_bar  | req.valid & req.ready
//  rsp     | out | max_area, overflow               | rsp.valid & rsp.ready
//
//  A taller bar goes straight to the push; other bars first pop the steps
//  not shorter than themselves, one pop per cycle through the stack memory read port.
//  A last bar then flushes the steps left on the stack and drains the area
//  multiply/compare pipeline (candidate and product registers), then loads
//  the result register; an earlier result not yet taken holds this step.
//  The result register decouples rsp: new requests are taken while it waits.
//  Synchronous active-high reset; stack memory is not cleared.
// ----------------------------------------------------------------------------
module histogram_max_rectangle_core #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   hmr_req_if.sink    req,
   hmr_rsp_if.source  rsp
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [hmr_pkg::ENTRY_W-1:0] mem [STACK_DEPTH];

   hmr_pkg::state_type state_ff, state_in;

   logic [hmr_pkg::BARW_W-1:0]   bar_w_ff, bar_w_in;
   logic [hmr_pkg::HEIGHT_W-1:0] bar_h_ff, bar_h_in;
   logic                         last_ff, last_in;
   logic                         taller_ff, taller_in;

   logic [CW-1:0]                count_ff, count_in;
   logic [hmr_pkg::STEPW_W-1:0]  acc_ff, acc_in;
   logic [hmr_pkg::HEIGHT_W-1:0] prev_ff, prev_in;
   logic                         ovf_ff, ovf_in;
   logic [hmr_pkg::AREA_W-1:0]   best_ff, best_in;

   logic [hmr_pkg::ENTRY_W-1:0]  rd_data_ff;
   logic [AW-1:0]                rd_idx;
   logic [CW-1:0]                count_dec;

   logic                         wr_en;
   logic [hmr_pkg::ENTRY_W-1:0]  wr_data;

   logic                         cand_vld_ff, cand_vld_in;
   logic [hmr_pkg::HEIGHT_W-1:0] cand_h_ff, cand_h_in;
   logic [hmr_pkg::STEPW_W-1:0]  cand_w_ff, cand_w_in;
   logic                         prod_vld_ff;
   logic [hmr_pkg::AREA_W-1:0]   prod_ff, prod_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hmr_pkg::AREA_W-1:0]   rsp_area_ff, rsp_area_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic [hmr_pkg::HEIGHT_W-1:0] top_h;
   logic [hmr_pkg::STEPW_W-1:0]  top_w;
   logic [hmr_pkg::STEPW_W-1:0]  acc_pop;
   logic [hmr_pkg::STEPW_W-1:0]  merge_w;
   logic                         empty;
   logic                         full;

   assign top_h   = rd_data_ff[hmr_pkg::HEIGHT_W-1:0];
   assign top_w   = rd_data_ff[hmr_pkg::ENTRY_W-1:hmr_pkg::HEIGHT_W];
   assign acc_pop = hmr_pkg::sat_add(acc_ff, top_w);
   assign merge_w = hmr_pkg::sat_add(acc_ff, {{(hmr_pkg::STEPW_W-hmr_pkg::BARW_W){1'b0}},
                                              bar_w_ff});
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(STACK_DEPTH));
   assign wr_data = {merge_w, bar_h_ff};
   assign prod_in = {{(hmr_pkg::AREA_W-hmr_pkg::HEIGHT_W){1'b0}}, cand_h_ff} *
                    {{(hmr_pkg::AREA_W-hmr_pkg::STEPW_W){1'b0}}, cand_w_ff};

   assign count_dec = count_in - CW'(1);
   assign rd_idx    = count_dec[AW-1:0];

   assign req.ready    = (state_ff == hmr_pkg::ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.max_area = rsp_area_ff;
   assign rsp.overflow = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      bar_w_in     = bar_w_ff;
      bar_h_in     = bar_h_ff;
      last_in      = last_ff;
      taller_in    = taller_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      ovf_in       = ovf_ff;
      cand_vld_in  = 1'b0;
      cand_h_in    = cand_h_ff;
      cand_w_in    = cand_w_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_area_in  = rsp_area_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      best_in      = (prod_vld_ff && (prod_ff > best_ff)) ? prod_ff : best_ff;

      case (state_ff)
         hmr_pkg::ST_IDLE: begin
            if (req.valid) begin
               bar_w_in  = req.bar_width;
               bar_h_in  = req.bar_height;
               last_in   = req.last_bar;
               taller_in = (req.bar_height > prev_ff);
               acc_in    = '0;
               state_in  = hmr_pkg::ST_POP;
            end
         end
         hmr_pkg::ST_POP: begin
            if (taller_ff || empty || (top_h < bar_h_ff)) begin
               cand_vld_in = 1'b1;
               cand_h_in   = bar_h_ff;
               cand_w_in   = merge_w;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               prev_in  = bar_h_ff;
               state_in = last_ff ? hmr_pkg::ST_FLUSH_RD : hmr_pkg::ST_IDLE;
            end else begin
               count_in    = count_ff - CW'(1);
               acc_in      = acc_pop;
               cand_vld_in = 1'b1;
               cand_h_in   = top_h;
               cand_w_in   = acc_pop;
            end
         end
         hmr_pkg::ST_FLUSH_RD: begin
            acc_in   = '0;
            state_in = hmr_pkg::ST_FLUSH;
         end
         hmr_pkg::ST_FLUSH: begin
            if (empty) begin
               state_in = hmr_pkg::ST_DRAIN;
            end else begin
               count_in    = count_ff - CW'(1);
               acc_in      = acc_pop;
               cand_vld_in = 1'b1;
               cand_h_in   = top_h;
               cand_w_in   = acc_pop;
            end
         end
         hmr_pkg::ST_DRAIN: begin
            if (!cand_vld_ff && !prod_vld_ff && (!rsp_valid_ff || rsp.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_ff;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               best_in      = '0;
               prev_in      = '0;
               ovf_in       = 1'b0;
               state_in     = hmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hmr_pkg::ST_IDLE;
         end
      endcase
   end

   // stack memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmr_pkg::ST_IDLE;
         count_ff     <= '0;
         prev_ff      <= '0;
         ovf_ff       <= 1'b0;
         best_ff      <= '0;
         cand_vld_ff  <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         ovf_ff       <= ovf_in;
         best_ff      <= best_in;
         cand_vld_ff  <= cand_vld_in;
         prod_vld_ff  <= cand_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_w_ff    <= bar_w_in;
      bar_h_ff    <= bar_h_in;
      last_ff     <= last_in;
      taller_ff   <= taller_in;
      acc_ff      <= acc_in;
      cand_h_ff   <= cand_h_in;
      cand_w_ff   <= cand_w_in;
      prod_ff     <= prod_in;
      rsp_area_ff <= rsp_area_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule

/* verif/tb_histogram_max_rectangle_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_max_rectangle_core
// Self-checking bench for the histogram max rectangle core. Bars stream into
// the request channel with random gaps. An in-bench step-stack predictor
// tracks every accepted request and queues the expected area and overflow
// flag for each closing bar. The result channel stalls at random and holds off
// for long stretches so the core backs up. Covered: directed corner bars and
// random histograms.
// ----------------------------------------------------------------------------
module tb_histogram_max_rectangle_core;

   localparam int STACK_DEPTH    = 1024;
   localparam int RANDOM_BARS    = 925;
   localparam int MIN_HISTOGRAMS = 25;
   localparam int CALM_TAIL      = 150;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [hmr_pkg::BARW_W-1:0]   width;
      logic [hmr_pkg::HEIGHT_W-1:0] height;
      logic                         last;
   } bar_type;

   typedef struct packed {
      logic [hmr_pkg::STEPW_W-1:0]  width;
      logic [hmr_pkg::HEIGHT_W-1:0] height;
   } step_type;

   typedef struct packed {
      logic [hmr_pkg::AREA_W-1:0] max_area;
      logic                       overflow;
   } rect_result_type;

   logic clock;
   logic reset;

   hmr_req_if req_ch ();
   hmr_rsp_if rsp_ch ();

   histogram_max_rectangle_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   bar_type         bar_queue[$];
   rect_result_type expected_rects[$];
   step_type        step_stack[$];

   logic [hmr_pkg::AREA_W-1:0]   best_area     = '0;
   logic [hmr_pkg::HEIGHT_W-1:0] prev_height   = '0;
   logic                         overflow_seen = 1'b0;

   int bars_queued    = 0;
   int bars_accepted  = 0;
   int rects_taken    = 0;
   int mismatch_count = 0;

   // ------------------------------------------------------------------------
   // step-stack predictor
   // ------------------------------------------------------------------------
   function automatic logic [hmr_pkg::STEPW_W-1:0] add_width(
      input logic [hmr_pkg::STEPW_W-1:0] a,
      input logic [hmr_pkg::STEPW_W-1:0] b);
      logic [hmr_pkg::STEPW_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[hmr_pkg::STEPW_W] ? hmr_pkg::STEPW_MAX : sum[hmr_pkg::STEPW_W-1:0];
   endfunction

   function automatic void note_area(input logic [hmr_pkg::HEIGHT_W-1:0] h,
                                     input logic [hmr_pkg::STEPW_W-1:0] w);
      logic [hmr_pkg::AREA_W-1:0] area;
      area = hmr_pkg::AREA_W'(h) * hmr_pkg::AREA_W'(w);
      if (area > best_area) best_area = area;
   endfunction

   function automatic void push_step(input logic [hmr_pkg::HEIGHT_W-1:0] h,
                                     input logic [hmr_pkg::STEPW_W-1:0] w);
      step_type s;
      if (step_stack.size() >= STACK_DEPTH) begin
         overflow_seen = 1'b1;
      end else begin
         s.width  = w;
         s.height = h;
         step_stack.push_back(s);
      end
   endfunction

   // pops every step at least h tall, returns the widened span
   function automatic logic [hmr_pkg::STEPW_W-1:0] pop_steps_down_to(
      input logic [hmr_pkg::HEIGHT_W-1:0] h);
      logic [hmr_pkg::STEPW_W-1:0] span;
      step_type                    top;
      span = '0;
      while (step_stack.size() > 0 && step_stack[$].height >= h) begin
         top  = step_stack.pop_back();
         span = add_width(span, top.width);
         note_area(top.height, span);
      end
      return span;
   endfunction

   function automatic void apply_bar(input logic [hmr_pkg::BARW_W-1:0] w,
                                     input logic [hmr_pkg::HEIGHT_W-1:0] h,
                                     input logic last);
      logic [hmr_pkg::STEPW_W-1:0] span;
      rect_result_type             r;
      if (h > prev_height) begin
         span = hmr_pkg::STEPW_W'(w);
      end else begin
         span = add_width(pop_steps_down_to(h), hmr_pkg::STEPW_W'(w));
      end
      note_area(h, span);
      push_step(h, span);
      prev_height = h;
      if (last) begin
         void'(pop_steps_down_to('0));
         r.max_area = best_area;
         r.overflow = overflow_seen;
         expected_rects.push_back(r);
         step_stack.delete();
         best_area     = '0;
         prev_height   = '0;
         overflow_seen = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_bar(input logic [hmr_pkg::BARW_W-1:0] w,
                                   input logic [hmr_pkg::HEIGHT_W-1:0] h,
                                   input logic last);
      bar_type b;
      b.width  = w;
      b.height = h;
      b.last   = last;
      bar_queue.push_back(b);
      bars_queued++;
   endfunction

   function automatic logic [hmr_pkg::BARW_W-1:0] random_width();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return hmr_pkg::BARW_W'($urandom_range(1, 16));
         default: return hmr_pkg::BARW_W'($urandom);
      endcase
   endfunction

   function automatic int add_random_histogram();
      int n, pick, style, base, level, shift, k;
      pick = $urandom_range(0, 19);
      if (pick < 14)      n = $urandom_range(1, 20);
      else if (pick < 19) n = $urandom_range(21, 80);
      else                n = $urandom_range(81, 200);
      style = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
         0:       base = 0;
         1:       base = 65535 - 7;
         default: base = $urandom_range(0, 65535 - 7);
      endcase
      level = $urandom_range(0, 65535);
      for (k = 0; k < n; k++) begin
         shift = $urandom_range(0, 300);
         case (style)
            0: begin
               if ($urandom_range(0, 7) == 0) level = 65535 * $urandom_range(0, 1);
               else level = $urandom_range(0, 65535);
            end
            1: begin
               level = base + $urandom_range(0, 7);
            end
            2: begin
               if ($urandom_range(0, 5) == 0) level = $urandom_range(0, level);
               else level = (level + shift > 65535) ? 65535 : level + shift;
            end
            default: begin
               if ($urandom_range(0, 5) == 0) level = $urandom_range(level, 65535);
               else level = (level < shift) ? 0 : level - shift;
            end
         endcase
         add_bar(random_width(), hmr_pkg::HEIGHT_W'(level), k == n - 1);
      end
      return n;
   endfunction

   function automatic bit in_tail();
      return bar_queue.size() < CALM_TAIL;
   endfunction

   function automatic void flag_mismatch(input string field,
                                         input logic [hmr_pkg::AREA_W-1:0] want_v,
                                         input logic [hmr_pkg::AREA_W-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
   endfunction

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   bar_type next_bar;
   int      send_gap   = 0;
   int      send_quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap   = 0;
         send_quiet = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_bar(req_ch.bar_width, req_ch.bar_height, req_ch.last_bar);
            bars_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_quiet > 0) send_quiet--;
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (!in_tail() && send_quiet == 0 && $urandom_range(0, 5) == 0) begin
               send_gap   = $urandom_range(1, 11) - 1;
               send_quiet = $urandom_range(0, 80);
               req_ch.valid <= 1'b0;
            end else if (bar_queue.size() > 0) begin
               next_bar = bar_queue.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.bar_width  <= next_bar.width;
               req_ch.bar_height <= next_bar.height;
               req_ch.last_bar   <= next_bar.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result ready: random stalls plus long hold-offs to back up the core
   // ------------------------------------------------------------------------
   int hold_left  = 0;
   int holds_done = 0;
   int take_gap   = 0;
   int take_quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left  = 0;
         take_gap   = 0;
         take_quiet = 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready) rects_taken++;
         if (take_quiet > 0) take_quiet--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!in_tail() && holds_done < 2 && rects_taken >= 12 + 18 * holds_done) begin
            hold_left = LONG_HOLD - 1;
            holds_done++;
            rsp_ch.ready <= 1'b0;
         end else if (in_tail()) begin
            rsp_ch.ready <= 1'b1;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (take_quiet == 0 && $urandom_range(0, 5) == 0) begin
            take_gap   = $urandom_range(1, 11) - 1;
            take_quiet = $urandom_range(0, 80);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   rect_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (expected_rects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result max_area %0d overflow %0b",
                        $time, rsp_ch.max_area, rsp_ch.overflow);
         end else begin
            want = expected_rects.pop_front();
            if (rsp_ch.max_area !== want.max_area)
               flag_mismatch("max_area", want.max_area, rsp_ch.max_area);
            if (rsp_ch.overflow !== want.overflow)
               flag_mismatch("overflow", hmr_pkg::AREA_W'(want.overflow),
                             hmr_pkg::AREA_W'(rsp_ch.overflow));
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int random_bars;
      int hist_count;

      reset = 1'b1;

      // corner bars
      add_bar('0, '0, 1'b1);
      add_bar('1, '1, 1'b1);
      add_bar(16'd3, 16'd5, 1'b0);
      add_bar(16'd2, 16'd7, 1'b0);
      add_bar(16'd4, 16'd3, 1'b0);
      add_bar(16'd1, 16'd3, 1'b0);
      add_bar(16'd5, 16'd0, 1'b0);
      add_bar(16'd2, 16'd9, 1'b1);
      add_bar(16'd0, 16'hFFFF, 1'b0);
      add_bar(16'd10, 16'd4, 1'b0);
      add_bar(16'd10, 16'd4, 1'b0);
      add_bar(16'd1, 16'd1, 1'b1);
      add_bar(16'd1, 16'd100, 1'b0);
      add_bar(16'd1, 16'd50, 1'b0);
      add_bar(16'd1, 16'd25, 1'b0);
      add_bar('1, 16'd0, 1'b1);
      add_bar('1, 16'd1, 1'b0);
      add_bar('1, '1, 1'b0);
      add_bar('1, '1, 1'b0);
      add_bar('0, 16'hFFFE, 1'b1);
      add_bar(16'd7, 16'd0, 1'b0);
      add_bar(16'd7, 16'd0, 1'b1);

      random_bars = 0;
      hist_count  = 0;
      while (random_bars < RANDOM_BARS || hist_count < MIN_HISTOGRAMS) begin
         random_bars += add_random_histogram();
         hist_count++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (bars_accepted < bars_queued) @(posedge clock);
      while (expected_rects.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_rects.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
